// File: rtl/core/ltnc_pkg.sv
// ----------------------------------------------------------------------------
// ltnc_pkg: shared types and constants for the line token classifier
// Transfer payloads, parse phases, token kinds and character codes.
// ----------------------------------------------------------------------------
package ltnc_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [63:0] integer_value;
    logic        line_end;
    logic        stream_end;
    logic        line_bad;
    logic        line_is_comment;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_GAP   = 2'd1,
    PH_TOKEN = 2'd2,
    PH_SKIP  = 2'd3
  } phase_t;

  // running class candidates and float-form tracking
  typedef struct packed {
    logic dec;
    logic oct;
    logic hex;
    logic flt;
    logic saw_e;
    logic saw_dot;
    logic last_e;
    logic last_sign;
    logic lead_dot;
  } class_flags_t;

  localparam class_flags_t CF_RESET = '{dec: 1'b1, oct: 1'b1, hex: 1'b1, flt: 1'b1,
                                        default: 1'b0};

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_WORD  = 3'd1;
  localparam logic [2:0] KIND_DEC   = 3'd2;
  localparam logic [2:0] KIND_OCT   = 3'd3;
  localparam logic [2:0] KIND_HEX   = 3'd4;
  localparam logic [2:0] KIND_FLOAT = 3'd5;

  localparam logic REG_LEGAL_LOW  = 1'b0;
  localparam logic REG_LEGAL_HIGH = 1'b1;

  localparam logic [7:0] LEGAL_LOW_RST  = 8'd33;
  localparam logic [7:0] LEGAL_HIGH_RST = 8'd126;

  localparam logic [2:0] INF_FAIL = 3'd7;

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_1       = 8'h31;
  localparam logic [7:0] CH_7       = 8'h37;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UZ      = 8'h5A;
  localparam logic [7:0] CH_A       = 8'h61;
  localparam logic [7:0] CH_E       = 8'h65;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_I       = 8'h69;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_X       = 8'h78;

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // letters of "inf", by position
  function automatic logic [7:0] inf_char(input logic [1:0] q);
    logic [7:0] r;
    case (q)
      2'd0:    r = CH_I;
      2'd1:    r = CH_N;
      default: r = CH_F;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/line_token_number_classifier.sv
// ----------------------------------------------------------------------------
// line_token_number_classifier
// Splits a byte stream into lines and whitespace-separated tokens and
// classifies each token as word, decimal, octal, hex or float.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one text byte per transfer (or an end-of-input marker).
//   out_* : at most one result per input byte: token kind, integer value and
//           line / stream closing flags.
//   cfg_* : legal byte range for token characters; write only while idle.
// Latency: a result appears on out_* the cycle after the byte that causes it
//   is accepted (one register stage).
// Throughput: one byte per cycle. All parsing state updates in the accept
//   cycle; the per-byte path is three constant multiply-accumulates (x10,
//   x8, x16) on VALUE_BITS-wide accumulators plus flag logic.
// Reset: synchronous, active low; parser returns to line start, legal range
//   returns to 33..126, output register empties.
// Stall: the output register holds its result while out_stall is high; the
//   input is stalled only when that register is full and stalled.
// ----------------------------------------------------------------------------
module line_token_number_classifier #(
  parameter int VALUE_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ltnc_pkg::in_item_t   in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output ltnc_pkg::out_item_t  out_data,
  // configuration
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_wr_data
);

  // accumulator plus room for one x16 step
  localparam int WB = VALUE_BITS + 4;

  // ---------------------------------------------------------------- state
  logic [7:0]             legal_low_r, legal_high_r;
  ltnc_pkg::phase_t       phase_r, phase_nxt;
  logic                   bad_r, bad_nxt;
  logic                   cmt_r, cmt_nxt;

  // token state: only read while phase_r is PH_TOKEN, so no reset
  logic [2:0]             pos_r, pos_nxt;
  logic [7:0]             fc0_r, fc0_nxt;
  logic [7:0]             fc1_r, fc1_nxt;
  ltnc_pkg::class_flags_t cf_r, cf_nxt;
  logic [2:0]             inf_r, inf_nxt;
  logic [VALUE_BITS-1:0]  acc_dec_r, acc_dec_nxt;
  logic [VALUE_BITS-1:0]  acc_oct_r, acc_oct_nxt;
  logic [VALUE_BITS-1:0]  acc_hex_r, acc_hex_nxt;
  logic [2:0]             ovf_r, ovf_nxt;

  logic                   out_valid_r;
  ltnc_pkg::out_item_t    out_data_r, out_data_nxt;

  logic                   in_accept;
  logic                   emit;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- classify
  // Classification of the token held in the state registers.
  logic                   c0_sign, float_ok;
  logic [2:0]             cls_kind;
  logic [VALUE_BITS-1:0]  cls_value;

  always_comb begin
    c0_sign   = ltnc_pkg::is_sign(fc0_r);
    float_ok  = cf_r.flt && !cf_r.last_e && !cf_r.last_sign && !cf_r.lead_dot;
    cls_kind  = float_ok ? ltnc_pkg::KIND_FLOAT : ltnc_pkg::KIND_WORD;
    cls_value = '0;
    if (inf_r == (c0_sign ? 3'd4 : 3'd3)) begin
      cls_kind = ltnc_pkg::KIND_FLOAT;
    end else if (fc0_r == ltnc_pkg::CH_0) begin
      if (pos_r >= 3'd2 && fc1_r == ltnc_pkg::CH_X && cf_r.hex) begin
        cls_kind  = ovf_r[2] ? ltnc_pkg::KIND_WORD : ltnc_pkg::KIND_HEX;
        cls_value = ovf_r[2] ? '0 : acc_hex_r;
      end else if (cf_r.oct) begin
        cls_kind  = ovf_r[1] ? ltnc_pkg::KIND_WORD : ltnc_pkg::KIND_OCT;
        cls_value = ovf_r[1] ? '0 : acc_oct_r;
      end else if (cf_r.dec) begin
        cls_kind  = ovf_r[0] ? ltnc_pkg::KIND_WORD : ltnc_pkg::KIND_DEC;
        cls_value = ovf_r[0] ? '0 : acc_dec_r;
      end
    end else if (fc0_r >= ltnc_pkg::CH_1 && fc0_r <= ltnc_pkg::CH_9 && cf_r.dec) begin
      cls_kind  = ovf_r[0] ? ltnc_pkg::KIND_WORD : ltnc_pkg::KIND_DEC;
      cls_value = ovf_r[0] ? '0 : acc_dec_r;
    end
  end

  // ---------------------------------------------------------------- byte step
  logic [7:0]             ch, lc;
  logic                   is_dig, is_sgn, is_hexl, at_start, signed0;
  logic [3:0]             dval, hval;
  logic [2:0]             p, q;
  logic [WB-1:0]          dec_sum, oct_sum, hex_sum;
  // token base: continue the current token, or start from a clean one
  logic [2:0]             b_pos;
  logic [7:0]             b_fc0, b_fc1;
  ltnc_pkg::class_flags_t b_cf;
  logic [2:0]             b_inf;
  logic [VALUE_BITS-1:0]  b_dec, b_oct, b_hex;
  logic [2:0]             b_ovf;
  logic                   lend, send;
  logic [2:0]             kind;
  logic [VALUE_BITS-1:0]  value;

  always_comb begin
    ch = in_data.text_byte;
    lc = (ch >= ltnc_pkg::CH_UA && ch <= ltnc_pkg::CH_UZ) ? ch + 8'd32 : ch;

    if (phase_r == ltnc_pkg::PH_TOKEN) begin
      b_pos = pos_r;  b_fc0 = fc0_r;  b_fc1 = fc1_r;  b_cf = cf_r;  b_inf = inf_r;
      b_dec = acc_dec_r;  b_oct = acc_oct_r;  b_hex = acc_hex_r;  b_ovf = ovf_r;
    end else begin
      b_pos = '0;  b_fc0 = '0;  b_fc1 = '0;  b_cf = ltnc_pkg::CF_RESET;  b_inf = '0;
      b_dec = '0;  b_oct = '0;  b_hex = '0;  b_ovf = '0;
    end

    p       = b_pos;
    is_dig  = (lc >= ltnc_pkg::CH_0) && (lc <= ltnc_pkg::CH_9);
    is_sgn  = ltnc_pkg::is_sign(lc);
    is_hexl = (lc >= ltnc_pkg::CH_A) && (lc <= ltnc_pkg::CH_F);
    dval    = 4'(lc - ltnc_pkg::CH_0);
    hval    = is_dig ? dval : 4'(lc - ltnc_pkg::CH_A + 8'd10);

    // constant multiply-accumulate; any carry past VALUE_BITS is overflow
    dec_sum = ({4'b0, b_dec} << 3) + ({4'b0, b_dec} << 1) + WB'(dval);
    oct_sum = ({4'b0, b_oct} << 3) + WB'(dval);
    hex_sum = ({4'b0, b_hex} << 4) + WB'(hval);

    pos_nxt = (p < 3'd7) ? p + 3'd1 : 3'd7;
    fc0_nxt = (p == 3'd0) ? lc : b_fc0;
    fc1_nxt = (p == 3'd1) ? lc : b_fc1;
    signed0 = ltnc_pkg::is_sign(fc0_nxt);

    acc_dec_nxt = b_dec;  acc_oct_nxt = b_oct;  acc_hex_nxt = b_hex;
    ovf_nxt = b_ovf;
    cf_nxt  = b_cf;

    if (is_dig) begin
      if (!b_ovf[0]) begin
        if (dec_sum[WB-1:VALUE_BITS] != '0) ovf_nxt[0] = 1'b1;
        else acc_dec_nxt = dec_sum[VALUE_BITS-1:0];
      end
    end else begin
      cf_nxt.dec = 1'b0;
    end

    if (lc >= ltnc_pkg::CH_0 && lc <= ltnc_pkg::CH_7) begin
      if (!b_ovf[1]) begin
        if (oct_sum[WB-1:VALUE_BITS] != '0) ovf_nxt[1] = 1'b1;
        else acc_oct_nxt = oct_sum[VALUE_BITS-1:0];
      end
    end else begin
      cf_nxt.oct = 1'b0;
    end

    if (p == 3'd1) begin
      if (lc != ltnc_pkg::CH_X) cf_nxt.hex = 1'b0;
    end else if (p >= 3'd2) begin
      if (is_dig || is_hexl) begin
        if (!b_ovf[2]) begin
          if (hex_sum[WB-1:VALUE_BITS] != '0) ovf_nxt[2] = 1'b1;
          else acc_hex_nxt = hex_sum[VALUE_BITS-1:0];
        end
      end else begin
        cf_nxt.hex = 1'b0;
      end
    end

    // float form tracking
    at_start = (p == 3'd0) || (p == 3'd1 && signed0);
    if (p == 3'd0 && is_sgn) begin
      cf_nxt.last_sign = 1'b1;
    end else begin
      if (cf_nxt.lead_dot && lc == ltnc_pkg::CH_E) cf_nxt.flt = 1'b0;
      cf_nxt.lead_dot = 1'b0;
      if (is_sgn) begin
        if (!cf_nxt.last_e) cf_nxt.flt = 1'b0;
      end else if (lc == ltnc_pkg::CH_E) begin
        if (cf_nxt.saw_e || at_start) cf_nxt.flt = 1'b0;
        cf_nxt.saw_e = 1'b1;
      end else if (lc == ltnc_pkg::CH_DOT) begin
        if (cf_nxt.saw_dot || cf_nxt.saw_e) cf_nxt.flt = 1'b0;
        cf_nxt.saw_dot = 1'b1;
        if (at_start) cf_nxt.lead_dot = 1'b1;
      end else if (!is_dig) begin
        cf_nxt.flt = 1'b0;
      end
      cf_nxt.last_e    = (lc == ltnc_pkg::CH_E);
      cf_nxt.last_sign = is_sgn;
    end

    // "inf" / "+inf" / "-inf" matcher
    q       = signed0 ? p - 3'd1 : p;
    inf_nxt = b_inf;
    if (b_inf != ltnc_pkg::INF_FAIL) begin
      if (p == 3'd0 && is_sgn) begin
        inf_nxt = 3'd1;
      end else if (q < 3'd3 && lc == ltnc_pkg::inf_char(q[1:0])) begin
        inf_nxt = p + 3'd1;
      end else begin
        inf_nxt = ltnc_pkg::INF_FAIL;
      end
    end

    // line-level control
    phase_nxt = phase_r;
    bad_nxt   = bad_r;
    cmt_nxt   = cmt_r;
    emit = 1'b0;  lend = 1'b0;  send = 1'b0;
    kind = ltnc_pkg::KIND_NONE;
    value = '0;

    if (in_data.end_of_input) begin
      if (phase_r == ltnc_pkg::PH_TOKEN) begin
        kind = cls_kind;  value = cls_value;
      end
      emit = 1'b1;  lend = 1'b1;  send = 1'b1;
    end else if (phase_r == ltnc_pkg::PH_SKIP) begin
      if (ch == ltnc_pkg::CH_NEWLINE) begin
        emit = 1'b1;  lend = 1'b1;
      end
    end else if (phase_r == ltnc_pkg::PH_START && ch == ltnc_pkg::CH_HASH) begin
      cmt_nxt   = 1'b1;
      phase_nxt = ltnc_pkg::PH_SKIP;
    end else if (ltnc_pkg::is_space(ch)) begin
      if (phase_r == ltnc_pkg::PH_TOKEN) begin
        kind = cls_kind;  value = cls_value;  emit = 1'b1;
      end
      if (ch == ltnc_pkg::CH_NEWLINE) begin
        emit = 1'b1;  lend = 1'b1;
      end
      if (phase_r == ltnc_pkg::PH_TOKEN || phase_r == ltnc_pkg::PH_START) begin
        phase_nxt = ltnc_pkg::PH_GAP;
      end
    end else if (ch < legal_low_r || ch > legal_high_r) begin
      bad_nxt   = 1'b1;
      phase_nxt = ltnc_pkg::PH_SKIP;
    end else begin
      phase_nxt = ltnc_pkg::PH_TOKEN;
    end

    // a closed line or stream restarts line state; the token state is
    // discarded implicitly since phase leaves PH_TOKEN
    if (lend) begin
      phase_nxt = ltnc_pkg::PH_START;
      bad_nxt   = 1'b0;
      cmt_nxt   = 1'b0;
    end

    out_data_nxt.token_kind      = kind;
    out_data_nxt.integer_value   = 64'(value);
    out_data_nxt.line_end        = lend;
    out_data_nxt.stream_end      = send;
    out_data_nxt.line_bad        = lend && bad_r;
    out_data_nxt.line_is_comment = lend && cmt_r;
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      legal_low_r  <= ltnc_pkg::LEGAL_LOW_RST;
      legal_high_r <= ltnc_pkg::LEGAL_HIGH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ltnc_pkg::REG_LEGAL_LOW:  legal_low_r  <= cfg_wr_data;
        default:                  legal_high_r <= cfg_wr_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ltnc_pkg::PH_START;
      bad_r       <= 1'b0;
      cmt_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r <= phase_nxt;
        bad_r   <= bad_nxt;
        cmt_r   <= cmt_nxt;
      end
      if (in_accept && emit) out_valid_r <= 1'b1;
      else if (!out_stall)   out_valid_r <= 1'b0;
    end
  end

  // token registers load only when a character joins a token
  always_ff @(posedge clk) begin
    if (in_accept && phase_nxt == ltnc_pkg::PH_TOKEN) begin
      pos_r     <= pos_nxt;
      fc0_r     <= fc0_nxt;
      fc1_r     <= fc1_nxt;
      cf_r      <= cf_nxt;
      inf_r     <= inf_nxt;
      acc_dec_r <= acc_dec_nxt;
      acc_oct_r <= acc_oct_nxt;
      acc_hex_r <= acc_hex_nxt;
      ovf_r     <= ovf_nxt;
    end
    if (in_accept && emit) out_data_r <= out_data_nxt;
  end

endmodule

// File: verif/tb_line_token_number_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_token_number_classifier: self-checking bench for the token classifier
// Feeds text bytes through the valid/stall input channel and checks every
// token result against an in-bench parser model. A short directed table
// comes first. Random lines of numbers, floats, words, comments, bad bytes
// and noise follow, under several legal byte ranges and random back-pressure.
// ----------------------------------------------------------------------------
module tb_line_token_number_classifier;

  localparam int VALUE_BITS = 64;

  // one stimulus row: the byte to send and, optionally, a hand-written result
  typedef struct {
    ltnc_pkg::in_item_t  item;
    bit                  has_typed;
    ltnc_pkg::out_item_t typed;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ltnc_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ltnc_pkg::out_item_t out_data;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_index = ltnc_pkg::REG_LEGAL_LOW;
  logic [7:0]          cfg_wr_data = '0;

  stim_row_t           stim_q[$];        // bytes still to be sent
  ltnc_pkg::out_item_t due_results[$];   // token results the block still owes us
  int                  err_cnt = 0;

  // traffic shaping knobs, set by the main sequence
  bit         tx_quiet = 1'b0;  // sender never idles
  bit         rx_quiet = 1'b0;  // receiver never stalls
  bit         hold_req = 1'b0;  // ask the receiver for one long hold-off
  int         hold_left = 0;

  // --------------------------------------------------------------------------
  // Parser model state: legal range, phase, running token flags
  // --------------------------------------------------------------------------
  logic [7:0]             lo_lim, hi_lim;
  ltnc_pkg::phase_t       ps;
  logic [2:0]             tok_len;          // saturates at 7
  logic [7:0]             lead_chars [2];   // first two bytes of the token
  ltnc_pkg::class_flags_t cf;
  logic [2:0]             inf_state;        // progress through [+-]inf, INF_FAIL once lost
  logic [63:0]            acc [3];          // decimal, octal, hex accumulators
  logic [2:0]             ovf;              // per-base overflow marks
  logic                   lf_bad, lf_cmt;

  line_token_number_classifier #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic bit byte_is_sign(input logic [7:0] c);
    return (c == ltnc_pkg::CH_PLUS) || (c == ltnc_pkg::CH_MINUS);
  endfunction

  // space and 9..13 separate tokens; 10 also closes the line
  function automatic bit byte_is_blank(input logic [7:0] c);
    return (c == ltnc_pkg::CH_SPACE) || ((c >= ltnc_pkg::CH_TAB) && (c <= ltnc_pkg::CH_CR));
  endfunction

  function automatic void clear_token();
    tok_len = '0;
    lead_chars[0] = '0;
    lead_chars[1] = '0;
    cf = ltnc_pkg::CF_RESET;
    inf_state = '0;
    acc[0] = '0;
    acc[1] = '0;
    acc[2] = '0;
    ovf = '0;
  endfunction

  function automatic void restart_stream();
    ps = ltnc_pkg::PH_START;
    lf_bad = 1'b0;
    lf_cmt = 1'b0;
    clear_token();
  endfunction

  // acc[k] = acc[k] * base + digit unless that passes 2^VALUE_BITS - 1
  function automatic void add_digit(input logic [1:0] k, input logic [63:0] base,
                                    input logic [63:0] digit);
    logic [63:0] maxv;
    maxv = {64{1'b1}} >> (64 - VALUE_BITS);
    if (ovf[k]) return;
    if (acc[k] > (maxv - digit) / base) ovf[k] = 1'b1;
    else acc[k] = acc[k] * base + digit;
  endfunction

  // fold one (already lower-cased) byte into the running token state
  function automatic void take_char(input logic [7:0] c);
    logic [2:0] p;
    logic [2:0] q;
    bit dig, sgn, signed0, at_start;
    p = tok_len;
    dig = (c >= ltnc_pkg::CH_0) && (c <= ltnc_pkg::CH_9);
    sgn = byte_is_sign(c);
    if (p < 2) lead_chars[p[0]] = c;
    signed0 = byte_is_sign(lead_chars[0]);

    if (dig) add_digit(2'd0, 64'd10, 64'(c - ltnc_pkg::CH_0));
    else cf.dec = 1'b0;
    if ((c >= ltnc_pkg::CH_0) && (c <= ltnc_pkg::CH_7))
      add_digit(2'd1, 64'd8, 64'(c - ltnc_pkg::CH_0));
    else cf.oct = 1'b0;
    // hex needs "0x" in front; digits count from the third byte on
    if (p == 1) begin
      if (c != ltnc_pkg::CH_X) cf.hex = 1'b0;
    end else if (p >= 2) begin
      if (dig) add_digit(2'd2, 64'd16, 64'(c - ltnc_pkg::CH_0));
      else if ((c >= ltnc_pkg::CH_A) && (c <= ltnc_pkg::CH_F))
        add_digit(2'd2, 64'd16, 64'(c - ltnc_pkg::CH_A + 8'd10));
      else cf.hex = 1'b0;
    end

    // float form tracking
    if ((p == 0) && sgn) begin
      cf.last_sign = 1'b1;
    end else begin
      at_start = (p == 0) || ((p == 1) && signed0);
      if (cf.lead_dot && (c == ltnc_pkg::CH_E)) cf.flt = 1'b0;
      cf.lead_dot = 1'b0;
      if (sgn) begin
        if (!cf.last_e) cf.flt = 1'b0;
      end else if (c == ltnc_pkg::CH_E) begin
        if (cf.saw_e || at_start) cf.flt = 1'b0;
        cf.saw_e = 1'b1;
      end else if (c == ltnc_pkg::CH_DOT) begin
        if (cf.saw_dot || cf.saw_e) cf.flt = 1'b0;
        cf.saw_dot = 1'b1;
        if (at_start) cf.lead_dot = 1'b1;
      end else if (!dig) begin
        cf.flt = 1'b0;
      end
      cf.last_e = (c == ltnc_pkg::CH_E);
      cf.last_sign = sgn;
    end

    if (inf_state != ltnc_pkg::INF_FAIL) begin
      if ((p == 0) && sgn) begin
        inf_state = 3'd1;
      end else begin
        q = signed0 ? p - 3'd1 : p;
        if (((q == 0) && (c == ltnc_pkg::CH_I)) || ((q == 1) && (c == ltnc_pkg::CH_N)) ||
            ((q == 2) && (c == ltnc_pkg::CH_F)))
          inf_state = p + 3'd1;
        else
          inf_state = ltnc_pkg::INF_FAIL;
      end
    end

    tok_len = (p < 7) ? p + 3'd1 : 3'd7;
  endfunction

  function automatic void classify(output logic [2:0] kind, output logic [63:0] value);
    logic [7:0] c0;
    bit float_ok;
    logic [1:0] sel;    // 0 dec, 1 oct, 2 hex, 3 no integer
    c0 = lead_chars[0];
    float_ok = cf.flt && !(cf.last_e || cf.last_sign || cf.lead_dot);
    sel = 2'd3;
    value = '0;
    if (inf_state == (byte_is_sign(c0) ? 3'd4 : 3'd3)) begin
      kind = ltnc_pkg::KIND_FLOAT;
      return;
    end
    if (c0 == ltnc_pkg::CH_0) begin
      if ((tok_len >= 2) && (lead_chars[1] == ltnc_pkg::CH_X) && cf.hex) sel = 2'd2;
      else if (cf.oct) sel = 2'd1;
      else if (cf.dec) sel = 2'd0;
    end else if ((c0 >= ltnc_pkg::CH_1) && (c0 <= ltnc_pkg::CH_9) && cf.dec) begin
      sel = 2'd0;
    end
    if (sel == 2'd3) begin
      kind = float_ok ? ltnc_pkg::KIND_FLOAT : ltnc_pkg::KIND_WORD;
    end else if (ovf[sel]) begin
      kind = ltnc_pkg::KIND_WORD;   // integer too big for VALUE_BITS
    end else begin
      kind = (sel == 2'd0) ? ltnc_pkg::KIND_DEC
                           : ((sel == 2'd1) ? ltnc_pkg::KIND_OCT : ltnc_pkg::KIND_HEX);
      value = acc[sel];
    end
  endfunction

  // advance the model by one accepted byte; emit says whether a result is due
  function automatic void parse_byte(input ltnc_pkg::in_item_t it, output bit emit,
                                     output ltnc_pkg::out_item_t res);
    logic [7:0]  c;
    logic [2:0]  kind;
    logic [63:0] value;
    bit          lend, send;
    c = it.text_byte;
    kind = ltnc_pkg::KIND_NONE;
    value = '0;
    emit = 1'b0;
    lend = 1'b0;
    send = 1'b0;
    if (it.end_of_input) begin
      if (ps == ltnc_pkg::PH_TOKEN) classify(kind, value);
      emit = 1'b1;
      lend = 1'b1;
      send = 1'b1;
    end else if (ps == ltnc_pkg::PH_SKIP) begin
      if (c == ltnc_pkg::CH_NEWLINE) begin
        emit = 1'b1;
        lend = 1'b1;
      end
    end else if ((ps == ltnc_pkg::PH_START) && (c == ltnc_pkg::CH_HASH)) begin
      lf_cmt = 1'b1;
      ps = ltnc_pkg::PH_SKIP;
    end else if (byte_is_blank(c)) begin
      if (ps == ltnc_pkg::PH_TOKEN) begin
        classify(kind, value);
        emit = 1'b1;
      end
      if (c == ltnc_pkg::CH_NEWLINE) begin
        emit = 1'b1;
        lend = 1'b1;
      end
      if ((ps == ltnc_pkg::PH_TOKEN) || (ps == ltnc_pkg::PH_START)) ps = ltnc_pkg::PH_GAP;
    end else if ((c < lo_lim) || (c > hi_lim)) begin
      lf_bad = 1'b1;
      ps = ltnc_pkg::PH_SKIP;
    end else begin
      if (ps != ltnc_pkg::PH_TOKEN) clear_token();
      if ((c >= ltnc_pkg::CH_UA) && (c <= ltnc_pkg::CH_UZ))
        c = c + (ltnc_pkg::CH_A - ltnc_pkg::CH_UA);
      take_char(c);
      ps = ltnc_pkg::PH_TOKEN;
    end

    res = '0;
    if (emit) begin
      res.token_kind      = kind;
      res.integer_value   = value;
      res.line_end        = lend;
      res.stream_end      = send;
      res.line_bad        = lend & lf_bad;
      res.line_is_comment = lend & lf_cmt;
      if (send) begin
        restart_stream();
      end else begin
        clear_token();
        if (lend) begin
          ps = ltnc_pkg::PH_START;
          lf_bad = 1'b0;
          lf_cmt = 1'b0;
        end
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] b);
    stim_row_t r;
    r.item.text_byte = b;
    r.item.end_of_input = 1'b0;
    r.has_typed = 1'b0;
    r.typed = '0;
    stim_q.push_back(r);
  endtask

  // a row whose result is known by inspection
  task automatic put_checked(input logic [7:0] b, input bit eoi, input logic [2:0] kind,
                             input logic [63:0] value, input bit lend, input bit send,
                             input bit bad, input bit cmt);
    stim_row_t r;
    r.item.text_byte = b;
    r.item.end_of_input = eoi;
    r.has_typed = 1'b1;
    r.typed.token_kind = kind;
    r.typed.integer_value = value;
    r.typed.line_end = lend;
    r.typed.stream_end = send;
    r.typed.line_bad = bad;
    r.typed.line_is_comment = cmt;
    stim_q.push_back(r);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // end of stream; the byte rides along with random content
  task automatic put_eoi();
    stim_row_t r;
    r.item.text_byte = 8'($urandom_range(0, 255));
    r.item.end_of_input = 1'b1;
    r.has_typed = 1'b0;
    r.typed = '0;
    stim_q.push_back(r);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 7))
      4:       return ltnc_pkg::CH_TAB;
      5:       return 8'd11;  // vertical tab
      6:       return 8'd12;  // form feed
      7:       return ltnc_pkg::CH_CR;
      default: return ltnc_pkg::CH_SPACE;
    endcase
  endfunction

  // a non-blank byte outside the current range, if one turns up quickly
  function automatic logic [7:0] pick_illegal();
    logic [7:0] b;
    b = 8'h00;
    repeat (8) begin
      b = 8'($urandom_range(0, 255));
      if (!byte_is_blank(b) && ((b < lo_lim) || (b > hi_lim))) return b;
    end
    return b;
  endfunction

  task automatic put_token();
    int r, n, n0;
    r = $urandom_range(0, 99);
    n0 = stim_q.size();
    if (r < 15) begin
      // decimal, with 2^64-1 / 2^64 now and then
      if ($urandom_range(0, 9) == 0) begin
        put_str($urandom_range(0, 1) ? "18446744073709551615" : "18446744073709551616");
      end else begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 22) : $urandom_range(0, 4);
        put_byte(pick("123456789"));
        repeat (n) put_byte(pick("0123456789"));
      end
    end else if (r < 25) begin
      // octal; a stray 8 or 9 turns it decimal, or a word if too big
      put_byte(ltnc_pkg::CH_0);
      if ($urandom_range(0, 9) == 0) begin
        put_str($urandom_range(0, 1) ? "1777777777777777777777" : "2000000000000000000000");
      end else begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 23) : $urandom_range(0, 4);
        repeat (n) put_byte(($urandom_range(0, 19) == 0) ? pick("89") : pick("01234567"));
      end
    end else if (r < 35) begin
      put_byte(ltnc_pkg::CH_0);
      put_byte(pick("xX"));
      if ($urandom_range(0, 9) == 0) begin
        put_str($urandom_range(0, 1) ? "ffffffffffffffff" : "10000000000000000");
      end else begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 18) : $urandom_range(0, 6);
        repeat (n) put_byte(($urandom_range(0, 29) == 0) ? pick("gG.")
                                                         : pick("0123456789abcdefABCDEF"));
      end
    end else if (r < 55) begin
      // float-ish: [sign] digits [. digits] [e [sign] digits], parts may go missing
      if ($urandom_range(0, 99) < 30) put_byte(pick("+-"));
      repeat ($urandom_range(0, 3)) put_byte(pick("0123456789"));
      if ($urandom_range(0, 1)) put_byte(ltnc_pkg::CH_DOT);
      repeat ($urandom_range(0, 3)) put_byte(pick("0123456789"));
      if ($urandom_range(0, 1)) begin
        put_byte(pick("eE"));
        if ($urandom_range(0, 2) == 0) put_byte(pick("+-"));
        repeat ($urandom_range(0, 3)) put_byte(pick("0123456789"));
      end
      if (stim_q.size() == n0) put_byte(pick("0123456789"));
    end else if (r < 63) begin
      if ($urandom_range(0, 1)) put_byte(pick("+-"));
      case ($urandom_range(0, 5))
        0: put_str("inf");
        1: put_str("INF");
        2: put_str("Inf");
        3: put_str("iNf");
        4: put_str("in");
        default: put_str("infs");
      endcase
    end else if (r < 80) begin
      repeat ($urandom_range(1, 10))
        put_byte(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
    end else if (r < 90) begin
      repeat ($urandom_range(1, 6)) put_byte(pick("+-.eE0123456789xX"));
    end else begin
      repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(33, 126)));
    end
  endtask

  task automatic put_line();
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      // comment: anything may follow the hash except a newline
      put_byte(ltnc_pkg::CH_HASH);
      repeat ($urandom_range(0, 8)) begin
        b = 8'($urandom_range(0, 255));
        put_byte((b == ltnc_pkg::CH_NEWLINE) ? 8'd11 : b);
      end
      put_byte(ltnc_pkg::CH_NEWLINE);
    end else if (r < 12) begin
      repeat ($urandom_range(0, 2)) put_byte(pick_blank());
      put_byte(ltnc_pkg::CH_NEWLINE);
    end else if (r < 20) begin
      repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
      put_byte(ltnc_pkg::CH_NEWLINE);
    end else begin
      if ($urandom_range(0, 4) == 0) put_byte(pick_blank());
      repeat ($urandom_range(1, 5)) begin
        put_token();
        repeat ($urandom_range(1, 2)) put_byte(pick_blank());
      end
      // bad line: an illegal byte, then junk that must be skipped
      if (r < 30) begin
        put_byte(pick_illegal());
        repeat ($urandom_range(0, 6)) put_byte(pick("0123456789 abcxyz.+-#"));
      end
      if ($urandom_range(0, 99) < 4) put_eoi();
      else put_byte(ltnc_pkg::CH_NEWLINE);
    end
  endtask

  task automatic fill_text(input int n_bytes);
    while (stim_q.size() < n_bytes) put_line();
  endtask

  // --------------------------------------------------------------------------
  // Input driver: one row per transfer, model updated at the accepting edge
  // --------------------------------------------------------------------------
  task automatic send_rows();
    stim_row_t           row;
    bit                  got;
    ltnc_pkg::out_item_t res;
    while (stim_q.size() > 0) begin
      row = stim_q.pop_front();
      @(negedge clk);
      while (!tx_quiet && ($urandom_range(0, 99) < 25)) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= row.item;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      parse_byte(row.item, got, res);
      if (row.has_typed) due_results.push_back(row.typed);
      else if (got) due_results.push_back(res);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // sender holds off until the block has returned everything it owes
  task automatic drain();
    while (due_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers written back to back while the block is idle
  task automatic set_legal_range(input logic [7:0] lo, input logic [7:0] hi);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= ltnc_pkg::REG_LEGAL_LOW;
    cfg_wr_data <= lo;
    @(negedge clk);
    cfg_index   <= ltnc_pkg::REG_LEGAL_HIGH;
    cfg_wr_data <= hi;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    lo_lim = lo;
    hi_lim = hi;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, a quiet mode, and one long counted hold-off
  // during which the output register fills and the input backs up.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
      out_stall <= 1'b1;
    end else if (rx_quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // every result transfer is matched against the oldest owed result
  always @(posedge clk) begin : check_results
    ltnc_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("result transfer with nothing owed: kind %0d value %0d",
               out_data.token_kind, out_data.integer_value);
        err_cnt++;
      end else begin
        want = due_results.pop_front();
        check_field("token_kind", 64'(want.token_kind), 64'(out_data.token_kind));
        check_field("integer_value", want.integer_value, out_data.integer_value);
        check_field("line_end", 64'(want.line_end), 64'(out_data.line_end));
        check_field("stream_end", 64'(want.stream_end), 64'(out_data.stream_end));
        check_field("line_bad", 64'(want.line_bad), 64'(out_data.line_bad));
        check_field("line_is_comment", 64'(want.line_is_comment),
                    64'(out_data.line_is_comment));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    lo_lim = ltnc_pkg::LEGAL_LOW_RST;
    hi_lim = ltnc_pkg::LEGAL_HIGH_RST;
    restart_stream();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed table, reset range 33..126
    put_checked(ltnc_pkg::CH_NEWLINE, 1'b0, ltnc_pkg::KIND_NONE, 64'd0,
                1'b1, 1'b0, 1'b0, 1'b0);                                  // empty line
    put_byte(ltnc_pkg::CH_HASH);
    put_byte(8'hFF);                                                      // skipped
    put_checked(ltnc_pkg::CH_NEWLINE, 1'b0, ltnc_pkg::KIND_NONE, 64'd0,
                1'b1, 1'b0, 1'b0, 1'b1);                                  // comment line
    put_str("0xF");
    put_checked(ltnc_pkg::CH_SPACE, 1'b0, ltnc_pkg::KIND_HEX, 64'd15,
                1'b0, 1'b0, 1'b0, 1'b0);
    put_str("017");
    put_checked(ltnc_pkg::CH_TAB, 1'b0, ltnc_pkg::KIND_OCT, 64'd15,
                1'b0, 1'b0, 1'b0, 1'b0);
    put_str("-iNf");
    put_checked(ltnc_pkg::CH_SPACE, 1'b0, ltnc_pkg::KIND_FLOAT, 64'd0,
                1'b0, 1'b0, 1'b0, 1'b0);
    put_str("19");
    put_checked(ltnc_pkg::CH_CR, 1'b0, ltnc_pkg::KIND_DEC, 64'd19,
                1'b0, 1'b0, 1'b0, 1'b0);
    put_byte(8'h00);                                                      // illegal byte
    put_checked(ltnc_pkg::CH_NEWLINE, 1'b0, ltnc_pkg::KIND_NONE, 64'd0,
                1'b1, 1'b0, 1'b1, 1'b0);                                  // bad line
    put_str(".Z");
    put_checked(8'hFF, 1'b1, ltnc_pkg::KIND_WORD, 64'd0,
                1'b1, 1'b1, 1'b0, 1'b0);                                  // end of input
    send_rows();
    drain();

    // default range, with a long receiver hold-off while bytes keep coming
    set_legal_range(ltnc_pkg::LEGAL_LOW_RST, ltnc_pkg::LEGAL_HIGH_RST);
    hold_req = 1'b1;
    fill_text(400);
    send_rows();
    drain();

    // everything legal
    set_legal_range(8'd0, 8'd255);
    fill_text(250);
    send_rows();
    drain();

    // digits only: words and signs make lines bad
    set_legal_range(ltnc_pkg::CH_0, ltnc_pkg::CH_9);
    fill_text(150);
    send_rows();
    drain();

    // empty range: every non-blank byte is illegal
    set_legal_range(8'd200, 8'd100);
    fill_text(100);
    send_rows();
    drain();

    set_legal_range(8'd0, 8'd0);
    fill_text(60);
    send_rows();
    drain();

    set_legal_range(8'd255, 8'd255);
    fill_text(60);
    send_rows();
    drain();

    repeat (2) begin
      set_legal_range(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      fill_text(100);
      send_rows();
      drain();
    end

    // back to default: a stretch at full rate, then random idling again
    set_legal_range(ltnc_pkg::LEGAL_LOW_RST, ltnc_pkg::LEGAL_HIGH_RST);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    fill_text(200);
    send_rows();
    drain();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    fill_text(250);
    send_rows();
    drain();

    // keep watching the output so a stray late result is still caught
    repeat (8) @(posedge clk);
    if ((err_cnt == 0) && (due_results.size() == 0)) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ltnc_pkg.sv
rtl/core/line_token_number_classifier.sv
verif/tb_line_token_number_classifier.sv
